// File: rtl/core/pfq_pkg.sv
// pfq_pkg: shared types and codes of the priority fifo queue
// operation and status codes, record layout; no dependencies
`default_nettype none

package pfq_pkg;

  // operation codes on op_i
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // stored record: id in the upper bits, priority in the lowest byte
  typedef struct packed {
    logic [15:0] id;
    logic [31:0] runtime;
    logic [7:0]  prio;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

endpackage

`default_nettype wire

// File: rtl/core/pfq_ram.sv
// pfq_ram: generic single-port-write, single-port-read memory
// registered read data; no dependencies
`default_nettype none

module pfq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/priority_fifo_queue_core.sv
// path from accept to result: push goes through ALLOC (once freed slots are reused),
// PUSH_WR and RESP; full push, empty pop/remove and unused codes go to RESP alone;
// pop and remove-highest go SCAN (one record per cycle), UNLINK, RELEASE and RESP.
// one transaction in flight; the next is taken the cycle after the result is registered.
// reset clears head, tail, count, free list and handshakes; the record and link memories
// are not cleared, unused slots come from a fill counter and then from the free list.
// uses pfq_pkg and pfq_ram
`default_nettype none

module priority_fifo_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 32,
  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [1:0]      op_i,
  input  wire logic [15:0]     process_id_i,
  input  wire logic [31:0]     run_time_i,
  input  wire logic [7:0]      priority_req_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic      [1:0]      status_o,
  output logic      [15:0]     out_id_o,
  output logic      [31:0]     out_runtime_o,
  output logic      [7:0]      out_priority_o,
  output logic      [CntW-1:0] occupancy_o
);

  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_PUSH_WR,
    ST_SCAN,
    ST_UNLINK,
    ST_RELEASE,
    ST_RESP
  } state_e;

  state_e state_q, state_d;

  logic [1:0]         op_q, op_d;
  pfq_pkg::rec_t      push_rec_q, push_rec_d;
  logic [IdxW-1:0]    slot_q, slot_d;
  logic [IdxW-1:0]    head_q, head_d;
  logic [IdxW-1:0]    tail_q, tail_d;
  logic [IdxW-1:0]    free_head_q, free_head_d;
  logic [CntW-1:0]    fresh_q, fresh_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    seen_q, seen_d;
  logic [IdxW-1:0]    cur_q, cur_d;
  logic [IdxW-1:0]    prev_q, prev_d;
  logic [IdxW-1:0]    best_q, best_d;
  logic [IdxW-1:0]    best_prev_q, best_prev_d;
  logic [IdxW-1:0]    best_nxt_q, best_nxt_d;
  pfq_pkg::rec_t      best_rec_q, best_rec_d;
  logic [1:0]         res_status_q, res_status_d;
  pfq_pkg::rec_t      res_rec_q, res_rec_d;
  logic               out_valid_q, out_valid_d;
  logic [1:0]         out_status_q, out_status_d;
  pfq_pkg::rec_t      out_rec_q, out_rec_d;
  logic [CntW-1:0]    out_occ_q, out_occ_d;

  // memory ports
  logic                     rec_we;
  logic [pfq_pkg::REC_W-1:0] rec_rdata;
  logic                     link_we;
  logic [IdxW-1:0]          link_waddr;
  logic [IdxW-1:0]          link_wdata;
  logic [IdxW-1:0]          link_rdata;
  logic [IdxW-1:0]          rd_addr;

  pfq_pkg::rec_t rd_rec;
  logic          in_accept;
  logic          better;

  assign rd_rec     = pfq_pkg::rec_t'(rec_rdata);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign better     = (seen_q == CntW'(1)) || (rd_rec.prio > best_rec_q.prio);

  pfq_ram #(
    .Width(pfq_pkg::REC_W),
    .Depth(QUEUE_DEPTH)
  ) u_rec_ram (
    .clk_i  (clk_i),
    .we_i   (rec_we),
    .waddr_i(slot_q),
    .wdata_i(push_rec_q),
    .raddr_i(rd_addr),
    .rdata_o(rec_rdata)
  );

  pfq_ram #(
    .Width(IdxW),
    .Depth(QUEUE_DEPTH)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .raddr_i(rd_addr),
    .rdata_o(link_rdata)
  );

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    push_rec_d   = push_rec_q;
    slot_d       = slot_q;
    head_d       = head_q;
    tail_d       = tail_q;
    free_head_d  = free_head_q;
    fresh_d      = fresh_q;
    count_d      = count_q;
    seen_d       = seen_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    best_d       = best_q;
    best_prev_d  = best_prev_q;
    best_nxt_d   = best_nxt_q;
    best_rec_d   = best_rec_q;
    res_status_d = res_status_q;
    res_rec_d    = res_rec_q;
    out_status_d = out_status_q;
    out_rec_d    = out_rec_q;
    out_occ_d    = out_occ_q;
    out_valid_d  = out_valid_q && out_stall_i;

    rec_we     = 1'b0;
    link_we    = 1'b0;
    link_waddr = best_q;
    link_wdata = free_head_q;
    rd_addr    = head_q;

    case (state_q)
      ST_IDLE: begin
        rd_addr = (op_i == pfq_pkg::OP_PUSH) ? free_head_q : head_q;
        if (in_accept) begin
          op_d         = op_i;
          push_rec_d   = '{id: process_id_i, runtime: run_time_i, prio: priority_req_i};
          res_status_d = pfq_pkg::STATUS_OK;
          res_rec_d    = '0;
          case (op_i)
            pfq_pkg::OP_PUSH: begin
              if (count_q == DepthCnt) begin
                res_status_d = pfq_pkg::STATUS_FULL;
                state_d      = ST_RESP;
              end else if (fresh_q < DepthCnt) begin
                slot_d  = fresh_q[IdxW-1:0];
                fresh_d = fresh_q + CntW'(1);
                state_d = ST_PUSH_WR;
              end else begin
                // reuse a freed slot, its link holds the next free one
                slot_d  = free_head_q;
                state_d = ST_ALLOC;
              end
            end
            pfq_pkg::OP_POP, pfq_pkg::OP_REMOVE: begin
              if (count_q == '0) begin
                res_status_d = pfq_pkg::STATUS_EMPTY;
                state_d      = ST_RESP;
              end else begin
                cur_d   = head_q;
                prev_d  = head_q;
                seen_d  = CntW'(1);
                state_d = ST_SCAN;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_ALLOC: begin
        free_head_d = link_rdata;
        state_d     = ST_PUSH_WR;
      end
      ST_PUSH_WR: begin
        rec_we = 1'b1;
        if (count_q != '0) begin
          link_we    = 1'b1;
          link_waddr = tail_q;
          link_wdata = slot_q;
        end else begin
          head_d = slot_q;
        end
        tail_d  = slot_q;
        count_d = count_q + CntW'(1);
        state_d = ST_RESP;
      end
      ST_SCAN: begin
        // read data belongs to cur_q; the next read follows its link
        rd_addr = link_rdata;
        if (better) begin
          best_d      = cur_q;
          best_prev_d = prev_q;
          best_rec_d  = rd_rec;
          best_nxt_d  = link_rdata;
        end
        if (op_q != pfq_pkg::OP_REMOVE || seen_q == count_q) begin
          state_d = ST_UNLINK;
        end else begin
          cur_d  = link_rdata;
          prev_d = cur_q;
          seen_d = seen_q + CntW'(1);
        end
      end
      ST_UNLINK: begin
        count_d   = count_q - CntW'(1);
        res_rec_d = best_rec_q;
        if (count_q == CntW'(1)) begin
          head_d = '0;
          tail_d = '0;
        end else if (best_q == head_q) begin
          head_d = best_nxt_q;
        end else begin
          link_we    = 1'b1;
          link_waddr = best_prev_q;
          link_wdata = best_nxt_q;
          if (best_q == tail_q) begin
            tail_d = best_prev_q;
          end
        end
        state_d = ST_RELEASE;
      end
      ST_RELEASE: begin
        link_we     = 1'b1;
        link_waddr  = best_q;
        link_wdata  = free_head_q;
        free_head_d = best_q;
        state_d     = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_rec_d    = res_rec_q;
          out_occ_d    = count_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= pfq_pkg::OP_PUSH;
      push_rec_q   <= '0;
      slot_q       <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      free_head_q  <= '0;
      fresh_q      <= '0;
      count_q      <= '0;
      seen_q       <= '0;
      cur_q        <= '0;
      prev_q       <= '0;
      best_q       <= '0;
      best_prev_q  <= '0;
      best_nxt_q   <= '0;
      best_rec_q   <= '0;
      res_status_q <= pfq_pkg::STATUS_OK;
      res_rec_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= pfq_pkg::STATUS_OK;
      out_rec_q    <= '0;
      out_occ_q    <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      push_rec_q   <= push_rec_d;
      slot_q       <= slot_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      free_head_q  <= free_head_d;
      fresh_q      <= fresh_d;
      count_q      <= count_d;
      seen_q       <= seen_d;
      cur_q        <= cur_d;
      prev_q       <= prev_d;
      best_q       <= best_d;
      best_prev_q  <= best_prev_d;
      best_nxt_q   <= best_nxt_d;
      best_rec_q   <= best_rec_d;
      res_status_q <= res_status_d;
      res_rec_q    <= res_rec_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_rec_q    <= out_rec_d;
      out_occ_q    <= out_occ_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_id_o       = out_rec_q.id;
  assign out_runtime_o  = out_rec_q.runtime;
  assign out_priority_o = out_rec_q.prio;
  assign occupancy_o    = out_occ_q;

  // never more records held than slots handed out by the fill counter
  a_count_le_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= fresh_q) && (fresh_q <= DepthCnt))
    else $error("record count exceeds allocated slots");

  // the list walk never runs past the held records
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (seen_q != '0) && (seen_q <= count_q))
    else $error("list walk beyond record count");

  // a full report only when every slot is taken
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == pfq_pkg::STATUS_FULL) |-> (occupancy_o == DepthCnt))
    else $error("full status with free slots");

  // a removal drops the count by exactly one
  a_unlink_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UNLINK) |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("removal did not decrement count");

endmodule

`default_nettype wire

// File: verif/testbench.sv
// testbench for priority_fifo_queue_core: directed and random push, pop and
// highest-priority removal checked against a queue model in a scoreboard class
// depends on pfq_pkg and the priority_fifo_queue_core rtl
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUEUE_DEPTH   = 32;
  localparam int unsigned OCC_W         = $clog2(QUEUE_DEPTH + 1);
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam int unsigned ITEM_TARGET   = 1550;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = QUEUE_DEPTH + 16;
  localparam int unsigned REPORT_MAX    = 10;

  typedef struct packed {
    logic [1:0]       status;
    logic [15:0]      id;
    logic [31:0]      runtime;
    logic [7:0]       prio;
    logic [OCC_W-1:0] occupancy;
  } outcome_t;

  class queue_checker;
    pfq_pkg::rec_t held_records[$];
    outcome_t      expected_results[$];
    int unsigned   checked;
    int unsigned   mismatches;
    int unsigned   pushes;
    int unsigned   full_rejects;
    int unsigned   pops;
    int unsigned   removals;
    int unsigned   empty_hits;
    int unsigned   peak;

    function void note_request(logic [1:0] op, pfq_pkg::rec_t rec);
      outcome_t want;
      int       best;
      want = '0;
      want.status = pfq_pkg::STATUS_OK;
      case (op)
        pfq_pkg::OP_PUSH: begin
          if (held_records.size() >= QUEUE_DEPTH) begin
            want.status = pfq_pkg::STATUS_FULL;
            full_rejects++;
          end else begin
            held_records.push_back(rec);
            pushes++;
          end
        end
        pfq_pkg::OP_POP, pfq_pkg::OP_REMOVE: begin
          if (held_records.size() == 0) begin
            want.status = pfq_pkg::STATUS_EMPTY;
            empty_hits++;
          end else begin
            best = 0;
            // strict compare keeps the frontmost record among equal priorities
            if (op == pfq_pkg::OP_REMOVE) begin
              for (int i = 1; i < held_records.size(); i++)
                if (held_records[i].prio > held_records[best].prio) best = i;
            end
            want.id      = held_records[best].id;
            want.runtime = held_records[best].runtime;
            want.prio    = held_records[best].prio;
            held_records.delete(best);
            if (op == pfq_pkg::OP_POP) pops++;
            else removals++;
          end
        end
        default: ;
      endcase
      want.occupancy = OCC_W'(held_records.size());
      if (held_records.size() > peak) peak = held_records.size();
      expected_results.push_back(want);
    endfunction

    function void check_response(outcome_t got);
      outcome_t want;
      checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: unexpected result status %0d id %h runtime %h prio %h occ %0d",
                   got.status, got.id, got.runtime, got.prio, got.occupancy);
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status || got.id !== want.id || got.runtime !== want.runtime ||
          got.prio !== want.prio || got.occupancy !== want.occupancy) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("ERROR: result %0d mismatch", checked);
          $display("  expected status %0d id %h runtime %h prio %h occ %0d",
                   want.status, want.id, want.runtime, want.prio, want.occupancy);
          $display("  actual   status %0d id %h runtime %h prio %h occ %0d",
                   got.status, got.id, got.runtime, got.prio, got.occupancy);
        end
      end
    endfunction
  endclass

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             in_valid_i     = 1'b0;
  logic [1:0]       op_i           = pfq_pkg::OP_PUSH;
  logic [15:0]      process_id_i   = '0;
  logic [31:0]      run_time_i     = '0;
  logic [7:0]       priority_req_i = '0;
  logic             out_stall_i    = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic [1:0]       status_o;
  logic [15:0]      out_id_o;
  logic [31:0]      out_runtime_o;
  logic [7:0]       out_priority_o;
  logic [OCC_W-1:0] occupancy_o;

  queue_checker sb = new();
  bit           quiet       = 1'b0;
  bit           run_done    = 1'b0;
  int unsigned  cycle_count = 0;

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  priority_fifo_queue_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .process_id_i  (process_id_i),
    .run_time_i    (run_time_i),
    .priority_req_i(priority_req_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .out_id_o      (out_id_o),
    .out_runtime_o (out_runtime_o),
    .out_priority_o(out_priority_o),
    .occupancy_o   (occupancy_o)
  );

  // mostly back to back, some short pauses, a few long ones
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic pfq_pkg::rec_t mk_record(logic [15:0] id, logic [31:0] runtime,
                                              logic [7:0] prio);
    pfq_pkg::rec_t rec;
    rec.id      = id;
    rec.runtime = runtime;
    rec.prio    = prio;
    return rec;
  endfunction

  // narrow priority range most of the time so ties are common
  function automatic pfq_pkg::rec_t random_record();
    pfq_pkg::rec_t rec;
    rec.id      = 16'($urandom);
    rec.runtime = $urandom;
    case ($urandom_range(0, 3))
      0, 1:    rec.prio = 8'($urandom_range(0, 3));
      2:       rec.prio = 8'($urandom);
      default: rec.prio = $urandom_range(0, 1) ? 8'hff : 8'h00;
    endcase
    return rec;
  endfunction

  task automatic send_op(logic [1:0] op, pfq_pkg::rec_t rec, bit last_one);
    int gap;
    in_valid_i     <= 1'b1;
    op_i           <= op;
    process_id_i   <= rec.id;
    run_time_i     <= rec.runtime;
    priority_req_i <= rec.prio;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(op, rec);
    gap = last_one ? 0 : pick_gap();
    if (gap > 0 || last_one) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin : result_backpressure
    int hold;
    forever begin
      @(posedge clk_i);
      hold = pick_gap();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      repeat ($urandom_range(0, 6)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_response({status_o, out_id_o, out_runtime_o, out_priority_o, occupancy_o});
  end

  initial begin : stimulus
    int unsigned real_items;
    int          phase_len;
    int          push_pct;
    int          r;
    logic [1:0]  op;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue, unused code, field extremes, a priority tie, highest priority in the middle and at the tail
    send_op(pfq_pkg::OP_POP,    random_record(), 1'b0);
    send_op(pfq_pkg::OP_REMOVE, random_record(), 1'b0);
    send_op(OP_UNUSED, mk_record(16'hffff, 32'hffff_ffff, 8'hff), 1'b0);
    send_op(pfq_pkg::OP_PUSH,   mk_record(16'h0000, 32'h0000_0000, 8'h00), 1'b0);
    send_op(pfq_pkg::OP_PUSH,   mk_record(16'hffff, 32'hffff_ffff, 8'hff), 1'b0);
    send_op(pfq_pkg::OP_PUSH,   mk_record(16'h1234, 32'h89ab_cdef, 8'hff), 1'b0);
    send_op(pfq_pkg::OP_PUSH,   mk_record(16'h0042, 32'h0000_0001, 8'h80), 1'b0);
    send_op(pfq_pkg::OP_REMOVE, random_record(), 1'b0);
    send_op(pfq_pkg::OP_REMOVE, random_record(), 1'b0);
    send_op(pfq_pkg::OP_POP,    random_record(), 1'b0);
    send_op(pfq_pkg::OP_REMOVE, random_record(), 1'b0);
    send_op(pfq_pkg::OP_POP,    random_record(), 1'b0);
    send_op(pfq_pkg::OP_PUSH,   mk_record(16'h0101, 32'h1111_1111, 8'h05), 1'b0);
    send_op(pfq_pkg::OP_PUSH,   mk_record(16'h0202, 32'h2222_2222, 8'h09), 1'b0);
    send_op(pfq_pkg::OP_PUSH,   mk_record(16'h0303, 32'h3333_3333, 8'h03), 1'b0);
    send_op(pfq_pkg::OP_REMOVE, random_record(), 1'b0);
    send_op(pfq_pkg::OP_PUSH,   mk_record(16'h0404, 32'h4444_4444, 8'hc8), 1'b0);
    send_op(pfq_pkg::OP_REMOVE, random_record(), 1'b0);
    send_op(pfq_pkg::OP_PUSH,   mk_record(16'h0505, 32'h5555_5555, 8'h01), 1'b0);
    send_op(pfq_pkg::OP_POP,    random_record(), 1'b0);
    send_op(pfq_pkg::OP_POP,    random_record(), 1'b0);
    send_op(pfq_pkg::OP_POP,    random_record(), 1'b0);
    send_op(pfq_pkg::OP_REMOVE, random_record(), 1'b0);

    // phases lean toward filling or draining so full and empty are both hit
    real_items = 0;
    phase_len  = 60;
    push_pct   = 90;
    while (real_items < ITEM_TARGET) begin
      if (phase_len == 0) begin
        phase_len = $urandom_range(40, 120);
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 50;
        endcase
        quiet = ($urandom_range(0, 3) == 0);
      end
      phase_len--;
      if ($urandom_range(0, 99) < push_pct) begin
        op = pfq_pkg::OP_PUSH;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) op = OP_UNUSED;
        else if (r < 52) op = pfq_pkg::OP_POP;
        else op = pfq_pkg::OP_REMOVE;
      end
      if (op != OP_UNUSED) real_items++;
      send_op(op, random_record(), real_items == ITEM_TARGET);
    end

    quiet = 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    run_done = 1'b1;
  end

  initial begin : run_control
    wait (run_done || cycle_count >= CYCLE_LIMIT);
    $display("covered %0d pushes (%0d refused full), %0d pops, %0d priority removals,",
             sb.pushes, sb.full_rejects, sb.pops, sb.removals);
    $display("%0d requests on an empty queue, peak occupancy %0d, %0d results, %0d mismatches",
             sb.empty_hits, sb.peak, sb.checked, sb.mismatches);
    if (!run_done) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("priority_fifo_queue_core test failed");
    end else if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("priority_fifo_queue_core test passed");
    end else begin
      if (sb.expected_results.size() != 0)
        $display("ERROR: %0d results never arrived", sb.expected_results.size());
      $display("priority_fifo_queue_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
